// File: sv/bfe_pkg.sv
package bfe_pkg;

  localparam int DEF_MAX_VARS    = 16;
  localparam int DEF_STACK_DEPTH = 32;
  localparam int QUEUE_DEPTH     = 4;
  localparam int NUM_SLOTS       = 52;
  localparam int SLOT_W          = 6;
  localparam int VIDX_W          = 6;
  localparam int VAR_W           = 16;
  localparam int S_DATA_W        = 8;
  localparam int M_DATA_W        = 8;

  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_NOT   = 8'h21;
  localparam logic [7:0] CH_AND   = 8'h26;
  localparam logic [7:0] CH_OR    = 8'h7C;
  localparam logic [7:0] CH_IMP   = 8'h5E;
  localparam logic [7:0] CH_EQV   = 8'h7E;
  localparam logic [7:0] CH_END   = 8'h23;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNDEF     = 2'd1;
  localparam logic [1:0] ST_VARS      = 2'd2;
  localparam logic [1:0] ST_MALFORMED = 2'd3;

  typedef enum logic [2:0] {
    OP_END   = 3'd0,
    OP_EQV   = 3'd1,
    OP_IMP   = 3'd2,
    OP_OR    = 3'd3,
    OP_AND   = 3'd4,
    OP_NOT   = 3'd5,
    OP_OPEN  = 3'd6,
    OP_CLOSE = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    TK_VAL,
    TK_OP,
    TK_ERR
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t  kind;
    op_t        op;
    logic       val;
    logic [1:0] err;
    logic       last;
  } token_t;

  typedef struct packed {
    logic push;
    logic full;
    logic pop;
    logic empty;
  } queue_ctl_t;

  typedef enum logic {
    F_IDLE,
    F_LOOK
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_POST,
    B_RED,
    B_CLS,
    B_VWAIT,
    B_OWAIT,
    B_OUT
  } back_state_t;

  function automatic logic [2:0] prec(input op_t op);
    return (op > OP_OPEN) ? 3'd6 : 3'(op);
  endfunction

  function automatic logic [1:0] flag_err(input logic [1:0] cur, input logic [1:0] code);
    return (cur == ST_OK || code < cur) ? code : cur;
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ);
  endfunction

  function automatic logic [SLOT_W-1:0] letter_slot(input logic [7:0] c);
    logic [SLOT_W-1:0] s;
    s = '0;
    if (c >= CH_LA && c <= CH_LZ) begin
      s = SLOT_W'(c - CH_LA);
    end else if (c >= CH_UA && c <= CH_UZ) begin
      s = SLOT_W'(c - CH_UA) + SLOT_W'(26);
    end
    return s;
  endfunction

endpackage

// File: sv/bfe_ram.sv
module bfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/bfe_front.sv
module bfe_front #(
  parameter int MAX_VARS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [bfe_pkg::S_DATA_W-1:0]  s_tdata,
  input  logic                          s_tlast,
  input  logic [bfe_pkg::VAR_W-1:0]     variable_values,
  input  logic                          q_full,
  output logic                          q_push,
  output bfe_pkg::token_t               q_tok
);
  import bfe_pkg::*;

  localparam int CNT_W = $clog2(MAX_VARS + 1);

  front_state_t            state, state_next;
  logic [7:0]              ch;
  logic                    last;
  logic [NUM_SLOTS-1:0]    valid, valid_next;
  logic [CNT_W-1:0]        count, count_next;
  logic [SLOT_W-1:0]       rd_slot, slot;
  logic [CNT_W-1:0]        rdata;
  logic                    tw_en;
  logic [VIDX_W-1:0]       idx;

  assign slot    = letter_slot(ch);
  assign rd_slot = (state == F_IDLE) ? letter_slot(s_tdata) : slot;

  bfe_ram #(.WIDTH(CNT_W), .DEPTH(NUM_SLOTS)) u_letters (
    .clk   (clk),
    .we    (tw_en),
    .waddr (slot),
    .wdata (count),
    .raddr (rd_slot),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      valid <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      valid <= valid_next;
      count <= count_next;
    end
    if (s_tvalid && s_tready) begin
      ch   <= s_tdata;
      last <= s_tlast;
    end
  end

  always_comb begin
    state_next = state;
    valid_next = valid;
    count_next = count;
    s_tready   = (state == F_IDLE);
    q_push     = 1'b0;
    tw_en      = 1'b0;
    idx        = '0;
    q_tok.kind = TK_ERR;
    q_tok.op   = OP_END;
    q_tok.val  = 1'b0;
    q_tok.err  = ST_OK;
    q_tok.last = last;

    if (is_letter(ch)) begin
      if (valid[slot]) begin
        q_tok.kind = TK_VAL;
        idx        = VIDX_W'(rdata);
      end else if (count >= CNT_W'(MAX_VARS)) begin
        q_tok.err = ST_VARS;
      end else begin
        q_tok.kind = TK_VAL;
        idx        = VIDX_W'(count);
      end
      q_tok.val = (idx < VIDX_W'(VAR_W)) ? variable_values[idx[3:0]] : 1'b0;
    end else begin
      q_tok.kind = TK_OP;
      unique case (ch)
        CH_OPEN:  q_tok.op = OP_OPEN;
        CH_CLOSE: q_tok.op = OP_CLOSE;
        CH_NOT:   q_tok.op = OP_NOT;
        CH_AND:   q_tok.op = OP_AND;
        CH_OR:    q_tok.op = OP_OR;
        CH_IMP:   q_tok.op = OP_IMP;
        CH_EQV:   q_tok.op = OP_EQV;
        CH_END: begin
          q_tok.kind = TK_ERR;
          q_tok.err  = ST_MALFORMED;
        end
        default: begin
          q_tok.kind = TK_ERR;
          q_tok.err  = ST_UNDEF;
        end
      endcase
    end

    unique case (state)
      F_IDLE: begin
        if (s_tvalid) begin
          state_next = F_LOOK;
        end
      end
      F_LOOK: begin
        if (!q_full) begin
          q_push     = 1'b1;
          state_next = F_IDLE;
          if (is_letter(ch) && !valid[slot] && count < CNT_W'(MAX_VARS)) begin
            tw_en            = 1'b1;
            valid_next[slot] = 1'b1;
            count_next       = count + CNT_W'(1);
          end
          if (last) begin
            valid_next = '0;
            count_next = '0;
          end
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

endmodule

// File: sv/bfe_queue.sv
module bfe_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  bfe_pkg::token_t push_tok,
  input  logic            pop,
  output bfe_pkg::token_t pop_tok,
  output logic            full,
  output logic            empty
);
  import bfe_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  token_t           slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full    = (fill == CNT_W'(QUEUE_DEPTH));
  assign empty   = (fill == '0);
  assign pop_tok = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - CNT_W'(1);
      end
    end
    if (push) begin
      slots[wr_ptr] <= push_tok;
    end
  end

endmodule

// File: sv/bfe_back.sv
module bfe_back #(
  parameter int STACK_DEPTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_empty,
  input  bfe_pkg::token_t               q_tok,
  output logic                          q_pop,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [bfe_pkg::M_DATA_W-1:0]  m_tdata
);
  import bfe_pkg::*;

  localparam int OA_W = $clog2(STACK_DEPTH);
  localparam int OD_W = $clog2(STACK_DEPTH + 1);

  back_state_t      state, state_next, ret, ret_next, ap_ret, pop_ret;
  token_t           tok, tok_next;
  logic [1:0]       err, err_next;
  logic [OD_W-1:0]  op_depth, op_depth_next, vd, vd_next, pend, pend_next;
  op_t              op_top, op_top_next;
  logic             v_top, v_top_next;
  logic [2:0]       p, p_next;
  logic             goal_end, goal_end_next;
  logic             m_tvalid_next;
  logic             out_truth, out_truth_next;
  logic [1:0]       out_status, out_status_next;
  logic             do_apply, do_pop, r;

  logic             ow_en, vw_en, vw_data;
  logic [OA_W-1:0]  ow_addr, or_addr, vw_addr, vr_addr;
  logic [2:0]       ow_data, o_rdata;
  logic             v_rdata;

  bfe_ram #(.WIDTH(3), .DEPTH(STACK_DEPTH)) u_ops (
    .clk   (clk),
    .we    (ow_en),
    .waddr (ow_addr),
    .wdata (ow_data),
    .raddr (or_addr),
    .rdata (o_rdata)
  );

  bfe_ram #(.WIDTH(1), .DEPTH(STACK_DEPTH)) u_vals (
    .clk   (clk),
    .we    (vw_en),
    .waddr (vw_addr),
    .wdata (vw_data),
    .raddr (vr_addr),
    .rdata (v_rdata)
  );

  assign m_tdata = {{(M_DATA_W - 3){1'b0}}, out_status, out_truth};

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_IDLE;
      err      <= ST_OK;
      op_depth <= OD_W'(1);
      op_top   <= OP_END;
      vd       <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      err      <= err_next;
      op_depth <= op_depth_next;
      op_top   <= op_top_next;
      vd       <= vd_next;
      m_tvalid <= m_tvalid_next;
    end
    tok        <= tok_next;
    ret        <= ret_next;
    pend       <= pend_next;
    v_top      <= v_top_next;
    p          <= p_next;
    goal_end   <= goal_end_next;
    out_truth  <= out_truth_next;
    out_status <= out_status_next;
  end

  always_comb begin
    state_next      = state;
    ret_next        = ret;
    tok_next        = tok;
    err_next        = err;
    op_depth_next   = op_depth;
    op_top_next     = op_top;
    vd_next         = vd;
    v_top_next      = v_top;
    pend_next       = pend;
    p_next          = p;
    goal_end_next   = goal_end;
    m_tvalid_next   = m_tvalid && !m_tready;
    out_truth_next  = out_truth;
    out_status_next = out_status;
    q_pop           = 1'b0;
    do_apply        = 1'b0;
    do_pop          = 1'b0;
    ap_ret          = B_RED;
    pop_ret         = B_RED;
    r               = 1'b0;
    ow_en           = 1'b0;
    ow_addr         = OA_W'(op_depth);
    ow_data         = tok.op;
    or_addr         = '0;
    vw_en           = 1'b0;
    vw_addr         = OA_W'(vd);
    vw_data         = 1'b0;
    vr_addr         = '0;

    unique case (state)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          tok_next   = q_tok;
          state_next = B_POST;
          unique case (q_tok.kind)
            TK_ERR: err_next = flag_err(err, q_tok.err);
            TK_VAL: begin
              if (err == ST_OK) begin
                if (vd >= OD_W'(STACK_DEPTH)) begin
                  err_next = flag_err(err, ST_MALFORMED);
                end else begin
                  vw_en      = 1'b1;
                  vw_data    = q_tok.val;
                  vd_next    = vd + OD_W'(1);
                  v_top_next = q_tok.val;
                end
              end
            end
            TK_OP: begin
              if (err == ST_OK) begin
                p_next        = prec(q_tok.op);
                goal_end_next = 1'b0;
                state_next    = B_RED;
              end
            end
            default: state_next = B_POST;
          endcase
        end
      end
      B_POST: begin
        if (!tok.last) begin
          state_next = B_IDLE;
        end else if (err == ST_OK) begin
          p_next        = prec(OP_END);
          goal_end_next = 1'b1;
          state_next    = B_RED;
        end else begin
          state_next = B_OUT;
        end
      end
      B_RED: begin
        if (!(prec(op_top) > p && op_top != OP_OPEN)) begin
          if (goal_end) begin
            if (op_top != OP_END || vd != OD_W'(1)) begin
              err_next = flag_err(err, ST_MALFORMED);
            end
            state_next = B_OUT;
          end else begin
            if (op_depth >= OD_W'(STACK_DEPTH)) begin
              err_next = flag_err(err, ST_MALFORMED);
            end else begin
              ow_en         = 1'b1;
              op_depth_next = op_depth + OD_W'(1);
              op_top_next   = tok.op;
            end
            state_next = B_POST;
          end
        end else if (op_top == OP_CLOSE) begin
          pend_next  = '0;
          state_next = B_CLS;
        end else begin
          do_apply = 1'b1;
          ap_ret   = B_RED;
        end
      end
      B_CLS: begin
        unique case (op_top)
          OP_CLOSE: begin
            pend_next = pend + OD_W'(1);
            do_pop    = 1'b1;
            pop_ret   = B_CLS;
          end
          OP_OPEN: begin
            pend_next = pend - OD_W'(1);
            do_pop    = 1'b1;
            pop_ret   = (pend == OD_W'(1)) ? B_RED : B_CLS;
          end
          OP_END: begin
            err_next   = flag_err(err, ST_MALFORMED);
            state_next = B_POST;
          end
          default: begin
            do_apply = 1'b1;
            ap_ret   = B_CLS;
          end
        endcase
      end
      B_VWAIT: begin
        unique case (op_top)
          OP_AND:  r = v_top & v_rdata;
          OP_OR:   r = v_top | v_rdata;
          OP_IMP:  r = ~v_rdata | v_top;
          default: r = (v_top == v_rdata);
        endcase
        vd_next    = vd - OD_W'(1);
        v_top_next = r;
        vw_en      = 1'b1;
        vw_addr    = OA_W'(vd - OD_W'(2));
        vw_data    = r;
        do_pop     = 1'b1;
        pop_ret    = ret;
      end
      B_OWAIT: begin
        op_top_next = op_t'(o_rdata);
        state_next  = ret;
      end
      B_OUT: begin
        if (!m_tvalid || m_tready) begin
          m_tvalid_next   = 1'b1;
          out_truth_next  = (err == ST_OK) ? v_top : 1'b0;
          out_status_next = err;
          err_next        = ST_OK;
          op_depth_next   = OD_W'(1);
          op_top_next     = OP_END;
          vd_next         = '0;
          state_next      = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase

    if (do_apply) begin
      if (vd == '0) begin
        err_next   = flag_err(err, ST_MALFORMED);
        state_next = B_POST;
      end else if (op_top == OP_NOT) begin
        v_top_next = ~v_top;
        vw_en      = 1'b1;
        vw_addr    = OA_W'(vd - OD_W'(1));
        vw_data    = ~v_top;
        do_pop     = 1'b1;
        pop_ret    = ap_ret;
      end else if (vd == OD_W'(1)) begin
        err_next   = flag_err(err, ST_MALFORMED);
        state_next = B_POST;
      end else begin
        vr_addr    = OA_W'(vd - OD_W'(2));
        ret_next   = ap_ret;
        state_next = B_VWAIT;
      end
    end

    if (do_pop) begin
      op_depth_next = op_depth - OD_W'(1);
      if (op_depth == OD_W'(2)) begin
        op_top_next = OP_END;
        state_next  = pop_ret;
      end else begin
        or_addr    = OA_W'(op_depth - OD_W'(2));
        ret_next   = pop_ret;
        state_next = B_OWAIT;
      end
    end
  end

endmodule

// File: sv/boolean_formula_evaluator.sv
// Channel  Dir  Fields (low bit first)             Handshake
// s_*      in   tdata: char_code[7:0]; tlast: is_last   tvalid/tready
// m_*      out  tdata: truth_value, status[1:0]     tvalid/tready
// cfg_*    in   cfg_wdata: variable_values[15:0]   cfg_we, no wait
//
// Front takes one character, looks it up in the letter-order RAM and pushes its
// token before it takes the next; it stalls while the 4-entry token queue is full.
// Back handles one token at a time, with a step more to push an operator or enter
// a group close; applying a binary operator reads the value stack and popping a
// parenthesis reads the operator stack, unless only the end marker stays below.
// Back stalls at the end check while the previous result is not taken.
// Reset is synchronous and clears stack depths and letter valid bits at once.
module boolean_formula_evaluator #(
  parameter int MAX_VARS    = bfe_pkg::DEF_MAX_VARS,
  parameter int STACK_DEPTH = bfe_pkg::DEF_STACK_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [bfe_pkg::S_DATA_W-1:0]  s_tdata,   // char_code[7:0]
  input  logic                          s_tlast,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [bfe_pkg::M_DATA_W-1:0]  m_tdata,   // truth_value, status[1:0], zeros
  input  logic                          cfg_we,
  input  logic [bfe_pkg::VAR_W-1:0]     cfg_wdata
);
  import bfe_pkg::*;

  logic [VAR_W-1:0] variable_values;
  logic             q_push, q_full, q_pop, q_empty;
  token_t           push_tok, pop_tok;

  always_ff @(posedge clk) begin
    if (rst) begin
      variable_values <= '0;
    end else if (cfg_we) begin
      variable_values <= cfg_wdata;
    end
  end

  bfe_front #(.MAX_VARS(MAX_VARS)) u_front (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tlast         (s_tlast),
    .variable_values (variable_values),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_tok           (push_tok)
  );

  bfe_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_tok (push_tok),
    .pop      (q_pop),
    .pop_tok  (pop_tok),
    .full     (q_full),
    .empty    (q_empty)
  );

  bfe_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_tok    (pop_tok),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("token pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("token popped from empty queue");

  a_err_false: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[2:1] != ST_OK) |-> !m_tdata[0])
    else $error("truth value set on failed formula");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result changed while waiting");

endmodule
